### design/lspd_pkg.sv
// Shared types, constants and codes for the LSB stego payload deframer.
package lspd_pkg;

  // Default build parameters
  localparam int HEADER_BYTES_DEF    = 54;
  localparam int MAGIC_MAX_CHARS_DEF = 8;

  // Fixed field widths
  localparam int BYTE_W      = 8;
  localparam int WORD_W      = 32;
  localparam int KIND_W      = 3;
  localparam int HDR_CNT_W   = 6;
  localparam int BIT_CNT_W   = 5;
  localparam int MAGIC_W     = 64;
  localparam int MLEN_W      = 4;
  localparam int MAGIC_IDX_W = 3;
  localparam int CFG_IDX_W   = 1;

  // Last bit position of a character and of a length word
  localparam logic [BIT_CNT_W-1:0] CHAR_TOP = 5'd7;
  localparam logic [BIT_CNT_W-1:0] LEN_TOP  = 5'd31;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_VALUE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGIC_LENGTH = 1'b1;

  // Configuration reset values
  localparam logic [MAGIC_W-1:0] MAGIC_VALUE_RST  = 64'd8998;
  localparam logic [MLEN_W-1:0]  MAGIC_LENGTH_RST = 4'd2;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_MAGIC    = 3'd1,
    PH_EXT_LEN  = 3'd2,
    PH_EXT_CHAR = 3'd3,
    PH_PAY_LEN  = 3'd4,
    PH_PAY_BYTE = 3'd5,
    PH_DONE     = 3'd6
  } phase_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_EXT_LEN  = 3'd0,
    KIND_EXT_CHAR = 3'd1,
    KIND_PAY_LEN  = 3'd2,
    KIND_PAY_BYTE = 3'd3,
    KIND_MISMATCH = 3'd4
  } kind_t;

  // One decoded result leaving the parser
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [WORD_W-1:0] value;
    logic              last;
  } result_t;

endpackage

### design/lspd_parser.sv
// Frame parser: header skip, LSB gathering, magic check and field decoding.
module lspd_parser #(
  parameter int HEADER_BYTES    = lspd_pkg::HEADER_BYTES_DEF,
  parameter int MAGIC_MAX_CHARS = lspd_pkg::MAGIC_MAX_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [lspd_pkg::BYTE_W-1:0]  image_byte,
  input  logic                         frame_start,
  input  logic [lspd_pkg::MAGIC_W-1:0] magic_value,
  input  logic [lspd_pkg::MLEN_W-1:0]  magic_length,
  output lspd_pkg::result_t            res
);
  import lspd_pkg::*;

  localparam phase_t PHASE_RST = (HEADER_BYTES == 0) ? PH_MAGIC : PH_HEADER;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES);
  localparam logic [MLEN_W-1:0] MLEN_MAX = MLEN_W'(MAGIC_MAX_CHARS);

  phase_t                 phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0]   header_count_r, header_count_nxt;
  logic [BIT_CNT_W-1:0]   bit_count_r, bit_count_nxt;
  logic [WORD_W-1:0]      bit_shift_r, bit_shift_nxt;
  logic [MAGIC_IDX_W-1:0] item_count_r, item_count_nxt;
  logic [WORD_W-1:0]      remaining_r, remaining_nxt;
  logic                   magic_bad_r, magic_bad_nxt;

  logic [WORD_W-1:0]      word;
  logic [BIT_CNT_W-1:0]   top;
  logic [MLEN_W-1:0]      len_used;
  logic [MLEN_W-1:0]      item_ext;
  logic [MAGIC_IDX_W-1:0] char_sel;
  logic [BYTE_W-1:0]      want;

  // Clamp the magic length into the supported range.
  always_comb begin
    if (magic_length == '0) begin
      len_used = MLEN_W'(1);
    end else if (magic_length > MLEN_MAX) begin
      len_used = MLEN_MAX;
    end else begin
      len_used = magic_length;
    end
  end

  // Next state and result for one word.
  always_comb begin
    phase_nxt        = phase_r;
    header_count_nxt = header_count_r;
    bit_count_nxt    = bit_count_r;
    bit_shift_nxt    = bit_shift_r;
    item_count_nxt   = item_count_r;
    remaining_nxt    = remaining_r;
    magic_bad_nxt    = magic_bad_r;
    word             = '0;
    top              = CHAR_TOP;
    item_ext         = '0;
    char_sel         = '0;
    want             = '0;
    res              = '0;

    if (step) begin
      // A frame start wipes the parse state before this word is used.
      if (frame_start) begin
        phase_nxt        = PHASE_RST;
        header_count_nxt = '0;
        bit_count_nxt    = '0;
        bit_shift_nxt    = '0;
        item_count_nxt   = '0;
        remaining_nxt    = '0;
        magic_bad_nxt    = 1'b0;
      end

      if (phase_nxt == PH_HEADER) begin
        header_count_nxt = header_count_nxt + HDR_CNT_W'(1);
        if (header_count_nxt >= HDR_LAST) begin
          phase_nxt = PH_MAGIC;
        end
      end else if (phase_nxt != PH_DONE) begin
        // Gather one LSB, MSB first.
        word = {bit_shift_nxt[WORD_W-2:0], image_byte[0]};
        top  = (phase_nxt == PH_EXT_LEN || phase_nxt == PH_PAY_LEN) ? LEN_TOP : CHAR_TOP;
        if (bit_count_nxt < top) begin
          bit_count_nxt = bit_count_nxt + BIT_CNT_W'(1);
          bit_shift_nxt = word;
        end else begin
          bit_count_nxt = '0;
          bit_shift_nxt = '0;
          unique case (phase_nxt)
            PH_MAGIC: begin
              item_ext = {1'b0, item_count_nxt};
              if (item_ext < len_used) begin
                char_sel = MAGIC_IDX_W'(len_used - MLEN_W'(1) - item_ext);
                want     = magic_value[char_sel*BYTE_W +: BYTE_W];
                if (word[BYTE_W-1:0] != want) begin
                  magic_bad_nxt = 1'b1;
                end
              end else begin
                magic_bad_nxt = 1'b1;
              end
              if (item_ext + MLEN_W'(1) >= len_used) begin
                item_count_nxt = '0;
                if (magic_bad_nxt) begin
                  phase_nxt = PH_DONE;
                  res.valid = 1'b1;
                  res.kind  = KIND_MISMATCH;
                  res.last  = 1'b1;
                end else begin
                  phase_nxt = PH_EXT_LEN;
                end
              end else begin
                item_count_nxt = item_count_nxt + MAGIC_IDX_W'(1);
              end
            end
            PH_EXT_LEN: begin
              remaining_nxt = word;
              phase_nxt     = (word != '0) ? PH_EXT_CHAR : PH_PAY_LEN;
              res.valid     = 1'b1;
              res.kind      = KIND_EXT_LEN;
              res.value     = word;
            end
            PH_EXT_CHAR: begin
              remaining_nxt = remaining_nxt - WORD_W'(1);
              if (remaining_nxt == '0) begin
                phase_nxt = PH_PAY_LEN;
              end
              res.valid = 1'b1;
              res.kind  = KIND_EXT_CHAR;
              res.value = {{(WORD_W-BYTE_W){1'b0}}, word[BYTE_W-1:0]};
            end
            PH_PAY_LEN: begin
              remaining_nxt = word;
              phase_nxt     = (word != '0) ? PH_PAY_BYTE : PH_DONE;
              res.valid     = 1'b1;
              res.kind      = KIND_PAY_LEN;
              res.value     = word;
              res.last      = (word == '0);
            end
            default: begin
              remaining_nxt = remaining_nxt - WORD_W'(1);
              if (remaining_nxt == '0) begin
                phase_nxt = PH_DONE;
              end
              res.valid = 1'b1;
              res.kind  = KIND_PAY_BYTE;
              res.value = {{(WORD_W-BYTE_W){1'b0}}, word[BYTE_W-1:0]};
              res.last  = (remaining_nxt == '0);
            end
          endcase
        end
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PHASE_RST;
      header_count_r <= '0;
      bit_count_r    <= '0;
      bit_shift_r    <= '0;
      item_count_r   <= '0;
      remaining_r    <= '0;
      magic_bad_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_count_r <= header_count_nxt;
      bit_count_r    <= bit_count_nxt;
      bit_shift_r    <= bit_shift_nxt;
      item_count_r   <= item_count_nxt;
      remaining_r    <= remaining_nxt;
      magic_bad_r    <= magic_bad_nxt;
    end
  end

endmodule

### design/lsb_stego_payload_deframer.sv
// Top level of the LSB stego payload deframer: channel registers and configuration.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in_     | input     | in_valid / in_stall  | in_image_byte, in_frame_start
//  out_    | output    | out_valid / out_stall| out_result_kind, out_value, out_last
//  cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One word per cycle while the output is not stalled: each accepted word is held in the input
// register and parsed as it moves on, and a field's result is registered in the output register.
// Throughput is set by the single parser pass between the two registers. Reset is synchronous
// and active low; it restores the configuration defaults and the header skip phase (the magic
// phase when HEADER_BYTES is zero). A stalled output holds its word and backs up into in_stall.
module lsb_stego_payload_deframer #(
  parameter int HEADER_BYTES    = lspd_pkg::HEADER_BYTES_DEF,
  parameter int MAGIC_MAX_CHARS = lspd_pkg::MAGIC_MAX_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lspd_pkg::BYTE_W-1:0]    in_image_byte,
  input  logic                           in_frame_start,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lspd_pkg::KIND_W-1:0]    out_result_kind,
  output logic [lspd_pkg::WORD_W-1:0]    out_value,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lspd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lspd_pkg::MAGIC_W-1:0]   cfg_wdata
);
  import lspd_pkg::*;

  logic [MAGIC_W-1:0] magic_value_r;
  logic [MLEN_W-1:0]  magic_length_r;

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_fs_r;

  logic              out_vld_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [WORD_W-1:0] out_value_r;
  logic              out_last_r;

  logic              advance;
  logic              in_take;
  result_t           res;

  // A held word moves on when the output register is free or being emptied.
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_value_r  <= MAGIC_VALUE_RST;
      magic_length_r <= MAGIC_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC_VALUE:  magic_value_r  <= cfg_wdata;
        CFG_MAGIC_LENGTH: magic_length_r <= cfg_wdata[MLEN_W-1:0];
        default:          magic_value_r  <= magic_value_r;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_image_byte;
      in_fs_r   <= in_frame_start;
    end
  end

  lspd_parser #(
    .HEADER_BYTES    (HEADER_BYTES),
    .MAGIC_MAX_CHARS (MAGIC_MAX_CHARS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .image_byte   (in_byte_r),
    .frame_start  (in_fs_r),
    .magic_value  (magic_value_r),
    .magic_length (magic_length_r),
    .res          (res)
  );

  // Output register: a new result loads, a taken one clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_kind_r  <= res.kind;
      out_value_r <= res.value;
      out_last_r  <= res.last;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = out_kind_r;
  assign out_value       = out_value_r;
  assign out_last        = out_last_r;

`ifndef SYNTHESIS
  // The parser never steps while a stalled result still occupies the output.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance |-> !(out_vld_r && out_stall))
    else $error("parser stepped into an occupied output register");

  // A magic mismatch always ends the frame.
  a_mismatch_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.valid && res.kind == KIND_MISMATCH) |-> res.last)
    else $error("magic mismatch without last");

  // An input stall is only raised while a word is held.
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stall without a held word");

  // A loaded result appears on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.valid) |=> out_valid)
    else $error("result lost on its way to the output");
`endif

endmodule
